// ===== design/ple_pkg.sv =====
package ple_pkg;

  // list geometry
  localparam int CAPACITY  = 64;
  localparam int ITEM_BITS = 16;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // fixed field widths of the stream items
  localparam int MODE_W  = 3;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  // common width for comparing a position against the count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_INS_POS  = 3'd2,
    MODE_REM_HEAD = 3'd3,
    MODE_REM_TAIL = 3'd4,
    MODE_REM_POS  = 3'd5,
    MODE_READ     = 3'd6
  } mode_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_RESP
  } state_t;

endpackage

// ===== design/positional_list_engine.sv =====
// Ordered list of up to 64 handles held in a single-port-write, single-port-read
// memory, driven by a small sequencer that moves one entry per cycle. Each
// command transfer yields exactly one result transfer. A positional insert or
// remove with n entries and position p streams the n-p entries at and above p
// through the memory port, one per cycle, then the count is updated and the
// result is presented until its handshake. A head remove on a full list is the
// longest case; a refused command or an unused mode skips the memory sequence
// and goes straight to the result. The block takes no new command until the
// current result has been transferred. Entry contents are not cleared at
// reset; only the count is, and only entries below the count are ever read.
module positional_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // mode[2:0], position[9:3], item[25:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // result_item[15:0], status[17:16], count[24:18], zero pad
);
  import ple_pkg::*;

  // input fields
  logic [MODE_W-1:0]    in_mode;
  logic [POS_W-1:0]     in_pos;
  logic [ITEM_BITS-1:0] in_item;

  assign in_mode = s_tdata[2:0];
  assign in_pos  = s_tdata[9:3];
  assign in_item = s_tdata[25:10];

  // sequencer and datapath registers
  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [MODE_W-1:0]    mode, mode_next;
  logic [ADDR_W-1:0]    where, where_next;
  logic [ITEM_BITS-1:0] item, item_next;
  logic [ITEM_BITS-1:0] got, got_next;
  status_t              status, status_next;
  logic [CNT_W-1:0]     left, left_next;
  logic [ADDR_W-1:0]    src, src_next;
  logic                 pend, pend_next;
  logic [ADDR_W-1:0]    pend_addr, pend_addr_next;

  // memory port
  logic [ITEM_BITS-1:0] mem [CAPACITY];
  logic [ITEM_BITS-1:0] rdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ITEM_BITS-1:0] mem_wdata;
  logic                 mem_re;

  // command decode
  status_t              dec_status;
  logic [CMP_W-1:0]     dec_where;
  logic [CNT_W-1:0]     dec_left;
  logic [ADDR_W-1:0]    dec_src;
  logic                 dec_go;
  logic                 is_ins;
  logic                 is_rem;

  // classify the held command
  assign is_ins = (mode == MODE_INS_HEAD) || (mode == MODE_INS_TAIL) ||
                  (mode == MODE_INS_POS);
  assign is_rem = (mode == MODE_REM_HEAD) || (mode == MODE_REM_TAIL) ||
                  (mode == MODE_REM_POS);

  // decode an incoming command against the current count
  always_comb begin
    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] p;
    c          = CMP_W'(cnt);
    p          = CMP_W'(in_pos);
    dec_status = STAT_OK;
    dec_where  = '0;
    dec_left   = '0;
    dec_src    = '0;
    dec_go     = 1'b0;
    case (in_mode)
      MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS: begin
        if (in_mode == MODE_INS_TAIL) begin
          dec_where = c;
        end else if (in_mode == MODE_INS_POS) begin
          dec_where = p;
        end
        if ((in_mode == MODE_INS_POS) && (p > c)) begin
          dec_status = STAT_BADPOS;
        end else if (cnt >= CNT_W'(CAPACITY)) begin
          dec_status = STAT_FULL;
        end
        dec_left = CNT_W'(c - dec_where);
        dec_src  = ADDR_W'(cnt - CNT_W'(1));
        dec_go   = (dec_status == STAT_OK);
      end
      MODE_REM_HEAD, MODE_REM_TAIL, MODE_REM_POS, MODE_READ: begin
        if (in_mode == MODE_REM_TAIL) begin
          dec_where = c - CMP_W'(1);
        end else if ((in_mode == MODE_REM_POS) || (in_mode == MODE_READ)) begin
          dec_where = p;
        end
        if (cnt == '0) begin
          dec_status = STAT_EMPTY;
        end else if (dec_where >= c) begin
          dec_status = STAT_BADPOS;
        end
        dec_left = (in_mode == MODE_READ) ? CNT_W'(1) : CNT_W'(c - dec_where);
        dec_src  = ADDR_W'(dec_where);
        dec_go   = (dec_status == STAT_OK);
      end
      default: begin
        dec_status = STAT_OK;
      end
    endcase
  end

  // next state, memory control and result capture
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    mode_next      = mode;
    where_next     = where;
    item_next      = item;
    got_next       = got;
    status_next    = status;
    left_next      = left;
    src_next       = src;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          mode_next   = in_mode;
          item_next   = in_item;
          where_next  = ADDR_W'(dec_where);
          status_next = dec_status;
          left_next   = dec_left;
          src_next    = dec_src;
          got_next    = '0;
          pend_next   = 1'b0;
          state_next  = dec_go ? ST_RUN : ST_RESP;
        end
      end
      ST_RUN: begin
        // issue the next read of the run
        if (left != '0) begin
          mem_re         = 1'b1;
          src_next       = is_ins ? src - ADDR_W'(1) : src + ADDR_W'(1);
          left_next      = left - CNT_W'(1);
          pend_next      = 1'b1;
          pend_addr_next = src;
        end else begin
          pend_next  = 1'b0;
          state_next = ST_FIN;
        end
        // retire the read issued last cycle
        if (pend) begin
          if (is_ins) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr + ADDR_W'(1);
            mem_wdata = rdata;
          end else if (is_rem && (pend_addr != where)) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr - ADDR_W'(1);
            mem_wdata = rdata;
          end else begin
            got_next = rdata;
          end
        end
      end
      ST_FIN: begin
        // place the new handle, then update the count
        if (is_ins) begin
          mem_we    = 1'b1;
          mem_waddr = where;
          mem_wdata = item;
          cnt_next  = cnt + CNT_W'(1);
        end else if (is_rem) begin
          cnt_next  = cnt - CNT_W'(1);
        end
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode      <= mode_next;
    where     <= where_next;
    item      <= item_next;
    got       <= got_next;
    status    <= status_next;
    left      <= left_next;
    src       <= src_next;
    pend_addr <= pend_addr_next;
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[src];
    end
  end

  // stream handshake and result packing
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_RESP);
  assign m_tdata  = {7'b0, COUNT_W'(cnt), status, got};

  // never take a command while a result waits
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("command accepted while a result is pending");

  // count stays within capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a refused command reports no handle
  a_zero_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status != STAT_OK) |-> (got == '0))
    else $error("nonzero handle with error status");

  // count changes only in the finish step
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FIN) |=> $stable(cnt))
    else $error("count changed outside finish step");

  // a refused command skips the memory sequence
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (dec_status != STAT_OK) |=> (state == ST_RESP))
    else $error("refused command entered the sequencer");

endmodule

// ===== verif/tb_positional_list_engine.sv =====
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  // mode code outside the command set; the block must leave the list alone
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int RAND_ITEMS = 1150;
  localparam int TAIL_WAIT = 80;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [POS_W-1:0]     pos;
    logic [ITEM_BITS-1:0] item;
  } cmd_t;

  typedef struct packed {
    logic [ITEM_BITS-1:0] item;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } rsp_t;

  typedef struct {
    cmd_t c;
    bit   typed;
    rsp_t r;
  } row_t;

  typedef enum int { PH_FILL, PH_DRAIN, PH_MIX } phase_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // mode[2:0], position[9:3], item[25:10], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // result_item[15:0], status[17:16], count[24:18], zero pad

  // expectation typed into the directed table travels with the command
  bit   cmd_typed = 1'b0;
  rsp_t cmd_exp = '0;

  // shadow copy of the list
  logic [ITEM_BITS-1:0] shadow_list [CAPACITY];
  int                   shadow_len = 0;

  rsp_t pending_results [$];
  row_t directed_rows [$];
  int   err_count = 0;

  positional_list_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shift later entries up and place the handle
  function automatic status_t put_entry(input int where, input logic [ITEM_BITS-1:0] value);
    int k;
    if (shadow_len >= CAPACITY) return STAT_FULL;
    for (k = shadow_len; k > where; k--) shadow_list[k] = shadow_list[k-1];
    shadow_list[where] = value;
    shadow_len++;
    return STAT_OK;
  endfunction

  // take the handle and close the gap
  function automatic status_t take_entry(input int where, output logic [ITEM_BITS-1:0] got);
    int k;
    got = '0;
    if (shadow_len == 0) return STAT_EMPTY;
    if (where >= shadow_len) return STAT_BADPOS;
    got = shadow_list[where];
    for (k = where; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
    shadow_len--;
    return STAT_OK;
  endfunction

  // apply one command to the shadow list and return its result
  function automatic rsp_t list_apply(input cmd_t c);
    rsp_t                 r;
    logic [ITEM_BITS-1:0] got;
    status_t              st;
    int                   pos;
    got = '0;
    st  = STAT_OK;
    pos = c.pos;
    case (c.mode)
      MODE_INS_HEAD: st = put_entry(0, c.item);
      MODE_INS_TAIL: st = put_entry(shadow_len, c.item);
      MODE_INS_POS: begin
        if (pos > shadow_len) st = STAT_BADPOS;
        else st = put_entry(pos, c.item);
      end
      MODE_REM_HEAD: st = take_entry(0, got);
      MODE_REM_TAIL: st = take_entry((shadow_len == 0) ? 0 : shadow_len - 1, got);
      MODE_REM_POS:  st = take_entry(pos, got);
      MODE_READ: begin
        if (shadow_len == 0) st = STAT_EMPTY;
        else if (pos >= shadow_len) st = STAT_BADPOS;
        else got = shadow_list[pos];
      end
      default: ;
    endcase
    if (st != STAT_OK) got = '0;
    r.item   = got;
    r.status = st;
    r.count  = shadow_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic flag_error(input string what, input int exp_val, input int got_val);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_val, got_val);
    err_count++;
  endtask

  task automatic add_row(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                         input logic [ITEM_BITS-1:0] item, input bit typed,
                         input logic [ITEM_BITS-1:0] e_item, input status_t e_st,
                         input logic [COUNT_W-1:0] e_cnt);
    row_t row;
    row.c     = '{mode: mode, pos: pos, item: item};
    row.typed = typed;
    row.r     = '{item: e_item, status: e_st, count: e_cnt};
    directed_rows.push_back(row);
  endtask

  // present one command and hold it until the transfer
  task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t exp);
    s_tdata   <= {6'b0, c.item, c.pos, c.mode};
    s_tvalid  <= 1'b1;
    cmd_typed <= typed;
    cmd_exp   <= exp;
    do @(posedge clk); while (!s_tready);
    s_tvalid  <= 1'b0;
  endtask

  // check results first, then predict the command taken at the same edge
  always @(posedge clk) begin
    rsp_t e;
    rsp_t pred;
    cmd_t c;
    if (rst) begin
      shadow_len = 0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          flag_error("unexpected result transfer", 0, 1);
        end else begin
          e = pending_results.pop_front();
          if (m_tdata[15:0] !== e.item) flag_error("result_item", e.item, m_tdata[15:0]);
          if (m_tdata[17:16] !== e.status) flag_error("status", e.status, m_tdata[17:16]);
          if (m_tdata[24:18] !== e.count) flag_error("count", e.count, m_tdata[24:18]);
        end
      end
      if (s_tvalid && s_tready) begin
        c.mode = s_tdata[2:0];
        c.pos  = s_tdata[9:3];
        c.item = s_tdata[25:10];
        pred = list_apply(c);
        pending_results.push_back(cmd_typed ? cmd_exp : pred);
      end
    end
  end

  // receiver stalls on a rotating pattern, reloaded now and then
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_age = 0;
  always @(posedge clk) begin
    if (pat_age == 95) begin
      pat_age   <= 0;
      ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      pat_age   <= pat_age + 1;
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
    m_tready <= ready_pat[0];
  end

  // stimulus
  initial begin
    cmd_t        c;
    int          burst_left;
    int          phase_left;
    int          gap;
    int          roll;
    int          sent;
    phase_kind_t phase;

    // empty list cases
    add_row(MODE_REM_HEAD, 7'd0,  16'h0000, 1, 16'h0000, STAT_EMPTY,  7'd0);
    add_row(MODE_REM_TAIL, 7'd0,  16'h0000, 1, 16'h0000, STAT_EMPTY,  7'd0);
    add_row(MODE_REM_POS,  7'd0,  16'h0000, 1, 16'h0000, STAT_EMPTY,  7'd0);
    add_row(MODE_READ,     7'd64, 16'h0000, 1, 16'h0000, STAT_EMPTY,  7'd0);
    add_row(MODE_INS_POS,  7'd1,  16'h1234, 1, 16'h0000, STAT_BADPOS, 7'd0);
    // build a short list, positional insert at the count acts as a tail insert
    add_row(MODE_INS_POS,  7'd0,  16'hFFFF, 1, 16'h0000, STAT_OK,     7'd1);
    add_row(MODE_INS_HEAD, 7'd0,  16'h0000, 1, 16'h0000, STAT_OK,     7'd2);
    add_row(MODE_INS_TAIL, 7'd64, 16'hA5A5, 1, 16'h0000, STAT_OK,     7'd3);
    add_row(MODE_INS_POS,  7'd3,  16'h5A5A, 1, 16'h0000, STAT_OK,     7'd4);
    add_row(MODE_INS_POS,  7'd64, 16'h0001, 1, 16'h0000, STAT_BADPOS, 7'd4);
    add_row(MODE_READ,     7'd1,  16'h0000, 1, 16'hFFFF, STAT_OK,     7'd4);
    add_row(MODE_READ,     7'd4,  16'h0000, 1, 16'h0000, STAT_BADPOS, 7'd4);
    add_row(MODE_READ,     7'd0,  16'hFFFF, 1, 16'h0000, STAT_OK,     7'd4);
    add_row(MODE_INS_POS,  7'd2,  16'h8000, 0, 16'h0000, STAT_OK,     7'd0);
    add_row(MODE_UNUSED,   7'd64, 16'hFFFF, 1, 16'h0000, STAT_OK,     7'd5);
    // out of range removes on a nonempty list
    add_row(MODE_REM_POS,  7'd5,  16'h0000, 1, 16'h0000, STAT_BADPOS, 7'd5);
    add_row(MODE_REM_POS,  7'd64, 16'h0000, 1, 16'h0000, STAT_BADPOS, 7'd5);
    // drain it again
    add_row(MODE_REM_POS,  7'd2,  16'h0000, 0, 16'h0000, STAT_OK,     7'd0);
    add_row(MODE_REM_TAIL, 7'd0,  16'h0000, 0, 16'h0000, STAT_OK,     7'd0);
    add_row(MODE_REM_HEAD, 7'd0,  16'h0000, 0, 16'h0000, STAT_OK,     7'd0);
    add_row(MODE_READ,     7'd0,  16'h0000, 0, 16'h0000, STAT_OK,     7'd0);
    add_row(MODE_REM_POS,  7'd0,  16'h0000, 0, 16'h0000, STAT_OK,     7'd0);
    add_row(MODE_REM_TAIL, 7'd0,  16'h0000, 0, 16'h0000, STAT_OK,     7'd0);
    add_row(MODE_REM_TAIL, 7'd0,  16'h0000, 1, 16'h0000, STAT_EMPTY,  7'd0);
    add_row(MODE_READ,     7'd0,  16'h0000, 1, 16'h0000, STAT_EMPTY,  7'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      @(negedge clk);
      @(posedge clk);
      send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);
    end

    // random part: fill, drain and mixed phases, sent in bursts
    burst_left = 0;
    phase_left = 0;
    phase      = PH_MIX;
    for (sent = 0; sent < RAND_ITEMS; sent++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        gap = 0;
      end
      repeat (gap) @(posedge clk);
      @(negedge clk);

      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 140);
        case ($urandom_range(0, 2))
          0:       phase = PH_FILL;
          1:       phase = PH_DRAIN;
          default: phase = PH_MIX;
        endcase
      end
      phase_left--;

      roll = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  c.mode = (roll < 85) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(3, 6));
        PH_DRAIN: c.mode = (roll < 80) ? 3'($urandom_range(3, 5)) :
                           (roll < 90) ? MODE_READ : 3'($urandom_range(0, 2));
        default:  c.mode = 3'($urandom_range(0, 6));
      endcase

      // mostly legal positions, the rest anywhere from 0 to 64
      if ($urandom_range(0, 4) == 0) c.pos = 7'($urandom_range(0, 64));
      else if (c.mode == MODE_INS_POS) c.pos = 7'($urandom_range(0, shadow_len));
      else c.pos = (shadow_len > 0) ? 7'($urandom_range(0, shadow_len - 1)) : 7'd0;

      case ($urandom_range(0, 19))
        0:       c.item = '0;
        1:       c.item = '1;
        default: c.item = 16'($urandom);
      endcase

      @(posedge clk);
      send_cmd(c, 1'b0, '0);
      burst_left--;
    end

    // drain outstanding results, then let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== positional_list_engine.f =====
design/ple_pkg.sv
design/positional_list_engine.sv
verif/tb_positional_list_engine.sv
